FILE: sv/sack_receive_window_core_macros.svh
// assertion macros for the sack receive window
`ifndef SACK_RECEIVE_WINDOW_CORE_MACROS_SVH
`define SACK_RECEIVE_WINDOW_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define SRW_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("srw assertion failed");

// next-cycle implication, disabled in reset
`define SRW_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("srw assertion failed");

`endif

FILE: sv/srw_pkg.sv
`timescale 1ns / 1ps
package srw_pkg;

    localparam int WINDOW_SLOTS = 256;
    localparam int SEQ_W        = 31;
    localparam int SLOT_W       = $clog2(WINDOW_SLOTS);
    localparam int COUNT_W      = SLOT_W + 1;
    localparam int STORE_SLOT_W = 8;
    localparam int STATUS_W     = 3;
    localparam int ROW_W        = 16;
    localparam int BIT_W        = $clog2(ROW_W);
    localparam int ROWS         = WINDOW_SLOTS / ROW_W;
    localparam int ROW_AW       = SLOT_W - BIT_W;

    typedef enum logic [STATUS_W-1:0] {
        STS_IN_ORDER     = 3'd0,
        STS_OUT_OF_ORDER = 3'd1,
        STS_CORRUPT      = 3'd2,
        STS_OVER_WINDOW  = 3'd3,
        STS_STALE        = 3'd4,
        STS_FIN          = 3'd5,
        STS_CLOSED       = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLASS,
        S_MARK,
        S_SCAN,
        S_OUT
    } state_t;

    typedef struct packed {
        logic              rd_en;
        logic [ROW_AW-1:0] rd_addr;
        logic              wr_en;
        logic [ROW_AW-1:0] wr_addr;
        logic [ROW_W-1:0]  wr_data;
        logic              clear;
    } map_req_t;

    // lowest clear bit of a bitmap row
    function automatic logic [BIT_W-1:0] first_zero(input logic [ROW_W-1:0] row);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int i = ROW_W - 1; i >= 0; i--) begin
            if (!row[i]) begin
                pos = BIT_W'(i);
            end
        end
        return pos;
    endfunction

    // lowest row that is not yet full
    function automatic logic [ROW_AW-1:0] first_open_row(input logic [ROWS-1:0] full);
        logic [ROW_AW-1:0] pos;
        pos = '0;
        for (int i = ROWS - 1; i >= 0; i--) begin
            if (!full[i]) begin
                pos = ROW_AW'(i);
            end
        end
        return pos;
    endfunction

endpackage

FILE: sv/srw_map_store.sv
`timescale 1ns / 1ps
module srw_map_store (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  srw_pkg::map_req_t             map_req,
    output logic [srw_pkg::ROW_W-1:0]     rd_data
);

    logic [srw_pkg::ROW_W-1:0] map_mem [srw_pkg::ROWS];
    logic [srw_pkg::ROW_W-1:0] rd_row_reg;
    logic                      rd_valid_reg;
    logic [srw_pkg::ROWS-1:0]  row_valid_reg;

    always_ff @(posedge aclk) begin
        if (map_req.wr_en) begin
            map_mem[map_req.wr_addr] <= map_req.wr_data;
        end
        if (map_req.rd_en) begin
            rd_row_reg   <= map_mem[map_req.rd_addr];
            rd_valid_reg <= row_valid_reg[map_req.rd_addr];
        end
    end

    // a row never written since the last clear reads as empty
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
        end else if (map_req.clear) begin
            row_valid_reg <= '0;
        end else if (map_req.wr_en) begin
            row_valid_reg[map_req.wr_addr] <= 1'b1;
        end
    end

    assign rd_data = rd_valid_reg ? rd_row_reg : '0;

endmodule

FILE: sv/sack_receive_window_core.sv
`timescale 1ns / 1ps
// Receiver window of a selective-repeat link with selective acks. Each segment header word
// gives one ack word. The received bitmap lives in a 16-row by 16-bit memory with a registered
// read, plus per-row valid and row-full flags. A stale, corrupt, over-window, fin or closed
// segment goes through S_CLASS and S_OUT before the next accept; an in-window segment goes
// through S_CLASS, S_MARK and S_OUT, and S_SCAN too when the base crosses a full row, because
// the next open row must be read from the map memory before the new base is known. A finished
// ack waits in the output register while the next segment is taken.
module sack_receive_window_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [srw_pkg::SEQ_W-1:0]           s_seq_number,
    input  logic                                s_is_fin,
    input  logic                                s_checksum_ok,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [srw_pkg::SEQ_W-1:0]           m_ack_number,
    output logic [srw_pkg::SEQ_W-1:0]           m_sack_number,
    output logic                                m_fin_ack,
    output logic [srw_pkg::STATUS_W-1:0]        m_status,
    output logic                                m_store_enable,
    output logic [srw_pkg::STORE_SLOT_W-1:0]    m_store_slot,
    output logic                                m_flush,
    output logic [srw_pkg::COUNT_W-1:0]         m_delivered_count
);

    srw_pkg::state_t                   state_reg, state_next;
    srw_pkg::map_req_t                 map_req;
    logic [srw_pkg::ROW_W-1:0]         map_rd;

    logic [srw_pkg::SEQ_W-1:0]         seq_reg, seq_next;
    logic                              fin_reg, fin_next;
    logic                              good_reg, good_next;
    logic                              closed_reg, closed_next;
    logic [srw_pkg::SEQ_W-1:0]         ws_reg, ws_next;
    logic [srw_pkg::SEQ_W-1:0]         ack_reg, ack_next;
    logic [srw_pkg::SLOT_W-1:0]        base_idx_reg, base_idx_next;
    logic [srw_pkg::SLOT_W-1:0]        idx_reg, idx_next;
    logic [srw_pkg::ROW_AW-1:0]        scan_row_reg, scan_row_next;
    logic [srw_pkg::ROWS-1:0]          row_full_reg, row_full_next;

    logic [srw_pkg::SEQ_W-1:0]         res_ack_reg, res_ack_next;
    logic [srw_pkg::SEQ_W-1:0]         res_sack_reg, res_sack_next;
    logic                              res_fin_ack_reg, res_fin_ack_next;
    srw_pkg::status_t                  res_status_reg, res_status_next;
    logic                              res_store_reg, res_store_next;
    logic [srw_pkg::STORE_SLOT_W-1:0]  res_slot_reg, res_slot_next;
    logic                              res_flush_reg, res_flush_next;
    logic [srw_pkg::COUNT_W-1:0]       res_count_reg, res_count_next;

    logic                              m_valid_reg, m_valid_next;
    logic [srw_pkg::SEQ_W-1:0]         m_ack_reg, m_ack_next;
    logic [srw_pkg::SEQ_W-1:0]         m_sack_reg, m_sack_next;
    logic                              m_fin_ack_reg, m_fin_ack_next;
    srw_pkg::status_t                  m_status_reg, m_status_next;
    logic                              m_store_reg, m_store_next;
    logic [srw_pkg::STORE_SLOT_W-1:0]  m_slot_reg, m_slot_next;
    logic                              m_flush_reg, m_flush_next;
    logic [srw_pkg::COUNT_W-1:0]       m_count_reg, m_count_next;

    logic [srw_pkg::SEQ_W:0]           seq_wide;
    logic [srw_pkg::SEQ_W:0]           win_end;
    logic                              over_window;
    logic                              stale;
    logic [srw_pkg::SLOT_W-1:0]        in_idx;
    logic [srw_pkg::ROW_AW-1:0]        mark_row;
    logic [srw_pkg::ROW_W-1:0]         merged_row;
    logic                              hit_base;
    logic                              row_done;
    logic [srw_pkg::ROWS-1:0]          full_upd;
    logic                              map_full;
    logic                              need_scan;
    logic                              out_free;
    logic [srw_pkg::SLOT_W-1:0]        mark_base;
    logic [srw_pkg::SLOT_W-1:0]        scan_base;
    logic [srw_pkg::SEQ_W-1:0]         ws_adv;

    srw_map_store u_map_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .map_req (map_req),
        .rd_data (map_rd)
    );

    assign seq_wide    = {1'b0, seq_reg};
    assign win_end     = {1'b0, ws_reg} + (srw_pkg::SEQ_W + 1)'(srw_pkg::WINDOW_SLOTS);
    assign over_window = seq_wide > win_end;
    assign stale       = seq_reg <= ws_reg;
    assign in_idx      = srw_pkg::SLOT_W'(seq_reg - ws_reg - srw_pkg::SEQ_W'(1));
    assign mark_row    = idx_reg[srw_pkg::SLOT_W-1:srw_pkg::BIT_W];
    assign merged_row  = map_rd | (srw_pkg::ROW_W'(1) << idx_reg[srw_pkg::BIT_W-1:0]);
    assign hit_base    = idx_reg == base_idx_reg;
    assign row_done    = &merged_row;
    assign map_full    = &full_upd;
    assign need_scan   = hit_base && row_done && !map_full;
    assign out_free    = !m_valid_reg || m_ready;
    assign mark_base   = {mark_row, srw_pkg::first_zero(merged_row)};
    assign scan_base   = {scan_row_reg, srw_pkg::first_zero(map_rd)};
    assign ws_adv      = ws_reg + srw_pkg::SEQ_W'(srw_pkg::WINDOW_SLOTS);

    always_comb begin
        full_upd           = row_full_reg;
        full_upd[mark_row] = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= srw_pkg::S_IDLE;
            closed_reg      <= 1'b0;
            ws_reg          <= '0;
            ack_reg         <= '0;
            base_idx_reg    <= '0;
            row_full_reg    <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            closed_reg      <= closed_next;
            ws_reg          <= ws_next;
            ack_reg         <= ack_next;
            base_idx_reg    <= base_idx_next;
            row_full_reg    <= row_full_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        seq_reg         <= seq_next;
        fin_reg         <= fin_next;
        good_reg        <= good_next;
        idx_reg         <= idx_next;
        scan_row_reg    <= scan_row_next;
        res_ack_reg     <= res_ack_next;
        res_sack_reg    <= res_sack_next;
        res_fin_ack_reg <= res_fin_ack_next;
        res_status_reg  <= res_status_next;
        res_store_reg   <= res_store_next;
        res_slot_reg    <= res_slot_next;
        res_flush_reg   <= res_flush_next;
        res_count_reg   <= res_count_next;
        m_ack_reg       <= m_ack_next;
        m_sack_reg      <= m_sack_next;
        m_fin_ack_reg   <= m_fin_ack_next;
        m_status_reg    <= m_status_next;
        m_store_reg     <= m_store_next;
        m_slot_reg      <= m_slot_next;
        m_flush_reg     <= m_flush_next;
        m_count_reg     <= m_count_next;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            srw_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = srw_pkg::S_CLASS;
                end
            end
            srw_pkg::S_CLASS: begin
                if (!closed_reg && !fin_reg && good_reg && !over_window && !stale) begin
                    state_next = srw_pkg::S_MARK;
                end else begin
                    state_next = srw_pkg::S_OUT;
                end
            end
            srw_pkg::S_MARK: begin
                state_next = need_scan ? srw_pkg::S_SCAN : srw_pkg::S_OUT;
            end
            srw_pkg::S_SCAN: begin
                state_next = srw_pkg::S_OUT;
            end
            srw_pkg::S_OUT: begin
                if (out_free) begin
                    state_next = srw_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = srw_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        seq_next         = seq_reg;
        fin_next         = fin_reg;
        good_next        = good_reg;
        closed_next      = closed_reg;
        ws_next          = ws_reg;
        ack_next         = ack_reg;
        base_idx_next    = base_idx_reg;
        idx_next         = idx_reg;
        scan_row_next    = scan_row_reg;
        row_full_next    = row_full_reg;
        res_ack_next     = res_ack_reg;
        res_sack_next    = res_sack_reg;
        res_fin_ack_next = res_fin_ack_reg;
        res_status_next  = res_status_reg;
        res_store_next   = res_store_reg;
        res_slot_next    = res_slot_reg;
        res_flush_next   = res_flush_reg;
        res_count_next   = res_count_reg;
        m_valid_next     = m_valid_reg;
        m_ack_next       = m_ack_reg;
        m_sack_next      = m_sack_reg;
        m_fin_ack_next   = m_fin_ack_reg;
        m_status_next    = m_status_reg;
        m_store_next     = m_store_reg;
        m_slot_next      = m_slot_reg;
        m_flush_next     = m_flush_reg;
        m_count_next     = m_count_reg;
        map_req          = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            srw_pkg::S_IDLE: begin
                if (s_valid) begin
                    seq_next  = s_seq_number;
                    fin_next  = s_is_fin;
                    good_next = s_checksum_ok;
                end
            end
            srw_pkg::S_CLASS: begin
                res_ack_next     = ack_reg;
                res_sack_next    = ack_reg;
                res_fin_ack_next = 1'b0;
                res_store_next   = 1'b0;
                res_slot_next    = '0;
                res_flush_next   = 1'b0;
                res_count_next   = '0;
                if (closed_reg) begin
                    res_status_next = srw_pkg::STS_CLOSED;
                end else if (fin_reg) begin
                    closed_next      = 1'b1;
                    res_fin_ack_next = 1'b1;
                    res_status_next  = srw_pkg::STS_FIN;
                    res_flush_next   = 1'b1;
                    res_count_next   = srw_pkg::COUNT_W'(base_idx_reg);
                    ws_next          = ws_adv;
                    row_full_next    = '0;
                    map_req.clear    = 1'b1;
                end else if (!good_reg) begin
                    res_status_next = srw_pkg::STS_CORRUPT;
                end else if (over_window) begin
                    res_status_next = srw_pkg::STS_OVER_WINDOW;
                end else if (stale) begin
                    res_status_next = srw_pkg::STS_STALE;
                    res_sack_next   = seq_reg;
                end else begin
                    res_status_next = srw_pkg::STS_OUT_OF_ORDER;
                    idx_next        = in_idx;
                    map_req.rd_en   = 1'b1;
                    map_req.rd_addr = in_idx[srw_pkg::SLOT_W-1:srw_pkg::BIT_W];
                end
            end
            srw_pkg::S_MARK: begin
                map_req.wr_en           = 1'b1;
                map_req.wr_addr         = mark_row;
                map_req.wr_data         = merged_row;
                row_full_next[mark_row] = row_done;
                res_sack_next           = seq_reg;
                res_store_next          = 1'b1;
                res_slot_next           = srw_pkg::STORE_SLOT_W'(idx_reg);
                res_status_next         = hit_base ? srw_pkg::STS_IN_ORDER
                                                   : srw_pkg::STS_OUT_OF_ORDER;
                if (hit_base) begin
                    if (!row_done) begin
                        base_idx_next = mark_base;
                        ack_next      = ws_reg + srw_pkg::SEQ_W'(mark_base);
                        res_ack_next  = ws_reg + srw_pkg::SEQ_W'(mark_base);
                    end else if (map_full) begin
                        // window complete: deliver all and advance
                        res_flush_next = 1'b1;
                        res_count_next = srw_pkg::COUNT_W'(srw_pkg::WINDOW_SLOTS);
                        ws_next        = ws_adv;
                        ack_next       = ws_adv;
                        res_ack_next   = ws_adv;
                        base_idx_next  = '0;
                        row_full_next  = '0;
                        map_req.clear  = 1'b1;
                    end else begin
                        scan_row_next   = srw_pkg::first_open_row(full_upd);
                        map_req.rd_en   = 1'b1;
                        map_req.rd_addr = srw_pkg::first_open_row(full_upd);
                    end
                end
            end
            srw_pkg::S_SCAN: begin
                base_idx_next = scan_base;
                ack_next      = ws_reg + srw_pkg::SEQ_W'(scan_base);
                res_ack_next  = ws_reg + srw_pkg::SEQ_W'(scan_base);
            end
            srw_pkg::S_OUT: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_ack_next     = res_ack_reg;
                    m_sack_next    = res_sack_reg;
                    m_fin_ack_next = res_fin_ack_reg;
                    m_status_next  = res_status_reg;
                    m_store_next   = res_store_reg;
                    m_slot_next    = res_slot_reg;
                    m_flush_next   = res_flush_reg;
                    m_count_next   = res_count_reg;
                end
            end
            default: begin
                map_req = '0;
            end
        endcase
    end

    assign s_ready           = state_reg == srw_pkg::S_IDLE;
    assign m_valid           = m_valid_reg;
    assign m_ack_number      = m_ack_reg;
    assign m_sack_number     = m_sack_reg;
    assign m_fin_ack         = m_fin_ack_reg;
    assign m_status          = m_status_reg;
    assign m_store_enable    = m_store_reg;
    assign m_store_slot      = m_slot_reg;
    assign m_flush           = m_flush_reg;
    assign m_delivered_count = m_count_reg;

endmodule

FILE: sv/srw_checker.sv
`timescale 1ns / 1ps
`include "sack_receive_window_core_macros.svh"
module srw_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [srw_pkg::SEQ_W-1:0]           m_ack_number,
    input logic                                m_fin_ack,
    input logic [srw_pkg::STATUS_W-1:0]        m_status,
    input logic                                m_store_enable,
    input logic                                m_flush,
    input logic [srw_pkg::COUNT_W-1:0]         m_delivered_count
);

    // a stalled ack word holds
    `SRW_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_ack_number))
    `SRW_ASSERT_IMPLY(a_fin_flush, aclk, aresetn, m_valid && m_fin_ack, m_flush && (m_status == srw_pkg::STS_FIN))
    `SRW_ASSERT_IMPLY(a_store_status, aclk, aresetn, m_valid, m_store_enable == ((m_status == srw_pkg::STS_IN_ORDER) || (m_status == srw_pkg::STS_OUT_OF_ORDER)))
    `SRW_ASSERT_IMPLY(a_full_count, aclk, aresetn, m_valid && m_flush && !m_fin_ack, m_delivered_count == srw_pkg::COUNT_W'(srw_pkg::WINDOW_SLOTS))
    `SRW_ASSERT_IMPLY(a_closed_quiet, aclk, aresetn, m_valid && (m_status == srw_pkg::STS_CLOSED), !m_store_enable && !m_flush && !m_fin_ack)

endmodule

bind sack_receive_window_core srw_checker u_srw_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_ack_number      (m_ack_number),
    .m_fin_ack         (m_fin_ack),
    .m_status          (m_status),
    .m_store_enable    (m_store_enable),
    .m_flush           (m_flush),
    .m_delivered_count (m_delivered_count)
);
